>>> sv/set_assoc_writeback_lru_cache_top_assert.svh
`ifndef SET_ASSOC_WRITEBACK_LRU_CACHE_TOP_ASSERT_SVH
`define SET_ASSOC_WRITEBACK_LRU_CACHE_TOP_ASSERT_SVH
// same-cycle implication, checked out of reset
`define SWLC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, checked out of reset
`define SWLC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> sv/swlc_pkg.sv
package swlc_pkg;
	// geometry
	localparam int ADDR_BITS  = 32;
	localparam int WAYS       = 4;
	localparam int SETS       = 64;
	localparam int LINE_WORDS = 8;
	localparam int DATA_W     = 64;
	localparam int OFF_W      = 3;
	localparam int WORD_W     = $clog2(LINE_WORDS);
	localparam int SET_W      = $clog2(SETS);
	localparam int WAY_W      = $clog2(WAYS);
	localparam int TAG_W      = ADDR_BITS - SET_W - WORD_W - OFF_W;
	localparam int LINE_W     = SET_W + WAY_W + WORD_W;
	localparam int RAM_DEPTH  = SETS * WAYS * LINE_WORDS;

	// line status codes
	localparam logic [1:0] ST_INVALID = 2'd0;
	localparam logic [1:0] ST_VALID   = 2'd1;
	localparam logic [1:0] ST_DIRTY   = 2'd2;

	// input modes
	localparam logic [1:0] MODE_READ  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_FILL  = 2'd2;

	// result kinds
	localparam logic [2:0] KIND_REJECT = 3'd0;
	localparam logic [2:0] KIND_RDATA  = 3'd1;
	localparam logic [2:0] KIND_WACK   = 3'd2;
	localparam logic [2:0] KIND_WB     = 3'd3;
	localparam logic [2:0] KIND_FILLRQ = 3'd4;

	// line data memory request
	typedef struct packed {
		logic              we;
		logic              re;
		logic [LINE_W-1:0] addr;
		logic [DATA_W-1:0] wdata;
	} ram_req_t;
endpackage

>>> sv/set_assoc_writeback_lru_cache_top.sv
// Hit: tag lookup, then a data memory read, then the result is registered; next word taken as it leaves.
// Miss: tag lookup, then per dirty victim word a data memory read then an emit,
// then the fill request; a clean miss goes from the lookup straight to its fill request.
// Fill words are taken while idle; the last one completes the saved access by a data memory read, then the result.
// Rate is set by the single-port line data memory and its registered read.
// Reset (async, active low) clears control; a pass over every set then invalidates lines, presets ages.
`include "set_assoc_writeback_lru_cache_top_assert.svh"
module set_assoc_writeback_lru_cache_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [31:0] address,
	input  logic [1:0]  access_bytes_log2,
	input  logic [63:0] data,
	input  logic [7:0]  cpu_tag,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [7:0]  response_id,
	output logic [63:0] payload,
	output logic [31:0] memory_address,
	output logic        last
);
	localparam int SET_W  = swlc_pkg::SET_W;
	localparam int WAY_W  = swlc_pkg::WAY_W;
	localparam int WORD_W = swlc_pkg::WORD_W;
	localparam int TAG_W  = swlc_pkg::TAG_W;
	localparam int OFF_W  = swlc_pkg::OFF_W;
	localparam int LOW_W  = OFF_W + WORD_W + SET_W;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_LOOKUP  = 3'd1;
	localparam logic [2:0] S_ACC_RD  = 3'd2;
	localparam logic [2:0] S_ACC_DN  = 3'd3;
	localparam logic [2:0] S_WB_RD   = 3'd4;
	localparam logic [2:0] S_WB_EMIT = 3'd5;
	localparam logic [2:0] S_FILLREQ = 3'd6;

	logic [2:0] state_q;
	logic       pending_q;
	logic [WORD_W-1:0] fill_cnt_q;
	logic [WORD_W-1:0] wb_cnt_q;
	logic       clr_q;
	logic [SET_W-1:0] clr_set_q;

	// saved access
	logic [1:0]  acc_mode_q;
	logic [31:0] acc_addr_q;
	logic [1:0]  acc_lg_q;
	logic [63:0] acc_data_q;
	logic [7:0]  acc_id_q;
	logic [WAY_W-1:0] acc_way_q;

	logic [1:0] status_mem [swlc_pkg::SETS][swlc_pkg::WAYS];
	logic [WAY_W-1:0] age_mem [swlc_pkg::SETS][swlc_pkg::WAYS];
	logic [1:0] status_row_s1 [swlc_pkg::WAYS];
	logic [WAY_W-1:0] age_row_s1 [swlc_pkg::WAYS];
	logic [TAG_W-1:0] tag_mem [swlc_pkg::SETS][swlc_pkg::WAYS];
	logic [TAG_W-1:0] tag_row_s1 [swlc_pkg::WAYS];

	logic        out_valid_q;
	logic [2:0]  kind_q;
	logic [7:0]  id_q;
	logic [63:0] pay_q;
	logic [31:0] maddr_q;
	logic        last_q;

	swlc_pkg::ram_req_t ram_req;
	logic [63:0] ram_rdata;

	swlc_line_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	// handshake
	logic slot_free, in_acc, in_cpu, fill_hit, fill_last;
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = !clr_q && (state_q == S_IDLE) && slot_free;
	assign in_acc    = in_valid && in_ready;
	assign in_cpu    = (mode == swlc_pkg::MODE_READ) || (mode == swlc_pkg::MODE_WRITE);
	assign fill_hit  = in_acc && (mode == swlc_pkg::MODE_FILL) && pending_q;
	assign fill_last = fill_cnt_q == WORD_W'(swlc_pkg::LINE_WORDS - 1);

	// aligned input address and its set
	logic [31:0] in_lo, in_addr;
	logic [SET_W-1:0] in_set;
	assign in_lo   = (32'd1 << access_bytes_log2) - 32'd1;
	assign in_addr = address & ~in_lo;
	assign in_set  = in_addr[OFF_W+WORD_W +: SET_W];

	// saved access fields
	logic [SET_W-1:0]  acc_set;
	logic [WORD_W-1:0] acc_word;
	logic [TAG_W-1:0]  acc_tag;
	assign acc_set  = acc_addr_q[OFF_W+WORD_W +: SET_W];
	assign acc_word = acc_addr_q[OFF_W +: WORD_W];
	assign acc_tag  = acc_addr_q[LOW_W +: TAG_W];

	// hit search, victim pick, LRU update
	logic hit_any;
	logic [WAY_W-1:0] hit_way, vic_way, touch_way;
	logic [WAY_W-1:0] new_age [swlc_pkg::WAYS];
	always_comb begin
		hit_any = 1'b0;
		hit_way = '0;
		vic_way = '0;
		for (int i = 0; i < swlc_pkg::WAYS; i++) begin
			if (!hit_any && status_row_s1[i] != swlc_pkg::ST_INVALID &&
			    tag_row_s1[i] == acc_tag) begin
				hit_any = 1'b1;
				hit_way = WAY_W'(i);
			end
		end
		for (int i = 1; i < swlc_pkg::WAYS; i++) begin
			if (age_row_s1[i] > age_row_s1[vic_way]) begin
				vic_way = WAY_W'(i);
			end
		end
		touch_way = hit_any ? hit_way : vic_way;
		for (int i = 0; i < swlc_pkg::WAYS; i++) begin
			if (WAY_W'(i) == touch_way) begin
				new_age[i] = '0;
			end else if (age_row_s1[i] < age_row_s1[touch_way]) begin
				new_age[i] = age_row_s1[i] + WAY_W'(1);
			end else begin
				new_age[i] = age_row_s1[i];
			end
		end
	end

	// byte lane select and merge
	logic [5:0]  shift;
	logic [63:0] msk, rd_val, wr_word;
	always_comb begin
		shift = {acc_addr_q[2:0], 3'b000};
		case (acc_lg_q)
			2'd0:    msk = 64'h0000_0000_0000_00FF;
			2'd1:    msk = 64'h0000_0000_0000_FFFF;
			2'd2:    msk = 64'h0000_0000_FFFF_FFFF;
			default: msk = '1;
		endcase
		rd_val  = (ram_rdata >> shift) & msk;
		wr_word = (ram_rdata & ~(msk << shift)) | ((acc_data_q & msk) << shift);
	end

	// data memory port
	always_comb begin
		ram_req = '0;
		case (state_q)
			S_IDLE: begin
				ram_req.we    = fill_hit;
				ram_req.addr  = {acc_set, acc_way_q, fill_cnt_q};
				ram_req.wdata = data;
			end
			S_LOOKUP: begin
				ram_req.re   = hit_any;
				ram_req.addr = {acc_set, hit_way, acc_word};
			end
			S_ACC_RD: begin
				ram_req.re   = 1'b1;
				ram_req.addr = {acc_set, acc_way_q, acc_word};
			end
			S_ACC_DN: begin
				ram_req.we    = slot_free && (acc_mode_q == swlc_pkg::MODE_WRITE);
				ram_req.addr  = {acc_set, acc_way_q, acc_word};
				ram_req.wdata = wr_word;
			end
			S_WB_RD: begin
				ram_req.re   = 1'b1;
				ram_req.addr = {acc_set, acc_way_q, wb_cnt_q};
			end
			default: ram_req = '0;
		endcase
	end

	// tag memory
	always_ff @(posedge clk) begin
		if (fill_hit && fill_last) begin
			tag_mem[acc_set][acc_way_q] <= acc_tag;
		end
		if (in_acc && in_cpu && !pending_q) begin
			tag_row_s1 <= tag_mem[in_set];
		end
	end

	// result word
	logic        load_out;
	logic [2:0]  o_kind;
	logic [7:0]  o_id;
	logic [63:0] o_pay;
	logic [31:0] o_maddr;
	logic        o_last;
	always_comb begin
		load_out = 1'b0;
		o_kind   = swlc_pkg::KIND_REJECT;
		o_id     = '0;
		o_pay    = '0;
		o_maddr  = '0;
		o_last   = 1'b1;
		case (state_q)
			S_IDLE: begin
				load_out = in_acc && in_cpu && pending_q;
				o_id     = cpu_tag;
			end
			S_ACC_DN: begin
				load_out = slot_free;
				o_id     = acc_id_q;
				if (acc_mode_q == swlc_pkg::MODE_WRITE) begin
					o_kind = swlc_pkg::KIND_WACK;
				end else begin
					o_kind = swlc_pkg::KIND_RDATA;
					o_pay  = rd_val;
				end
			end
			S_WB_EMIT: begin
				load_out = slot_free;
				o_kind   = swlc_pkg::KIND_WB;
				o_pay    = ram_rdata;
				o_maddr  = {tag_row_s1[acc_way_q], acc_set, (OFF_W + WORD_W)'(0)};
				o_last   = 1'b0;
			end
			S_FILLREQ: begin
				load_out = slot_free;
				o_kind   = swlc_pkg::KIND_FILLRQ;
				o_maddr  = {acc_addr_q[31:OFF_W+WORD_W], (OFF_W + WORD_W)'(0)};
			end
			default: load_out = 1'b0;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			kind_q  <= o_kind;
			id_q    <= o_id;
			pay_q   <= o_pay;
			maddr_q <= o_maddr;
			last_q  <= o_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign response_id    = id_q;
	assign payload        = pay_q;
	assign memory_address = maddr_q;
	assign last           = last_q;

	// saved access capture
	always_ff @(posedge clk) begin
		if (in_acc && in_cpu && !pending_q) begin
			acc_mode_q <= mode;
			acc_addr_q <= in_addr;
			acc_lg_q   <= access_bytes_log2;
			acc_data_q <= data;
			acc_id_q   <= cpu_tag;
		end
		if (state_q == S_LOOKUP) begin
			acc_way_q <= touch_way;
		end
	end

	// clearing pass over the status and age memories after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_set_q <= '0;
		end else if (clr_q) begin
			clr_set_q <= clr_set_q + SET_W'(1);
			if (clr_set_q == SET_W'(swlc_pkg::SETS - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// line status and LRU age memories, row read at accept
	always_ff @(posedge clk) begin
		if (clr_q) begin
			for (int j = 0; j < swlc_pkg::WAYS; j++) begin
				status_mem[clr_set_q][j] <= swlc_pkg::ST_INVALID;
				age_mem[clr_set_q][j]    <= WAY_W'(swlc_pkg::WAYS - 1 - j);
			end
		end else begin
			if (fill_hit && fill_last) begin
				status_mem[acc_set][acc_way_q] <= swlc_pkg::ST_VALID;
			end
			if (state_q == S_LOOKUP) begin
				age_mem[acc_set] <= new_age;
				if (!hit_any) begin
					status_mem[acc_set][vic_way] <= swlc_pkg::ST_INVALID;
				end
			end
			if (state_q == S_ACC_DN && slot_free && acc_mode_q == swlc_pkg::MODE_WRITE) begin
				status_mem[acc_set][acc_way_q] <= swlc_pkg::ST_DIRTY;
			end
		end
		if (in_acc && in_cpu && !pending_q) begin
			status_row_s1 <= status_mem[in_set];
			age_row_s1    <= age_mem[in_set];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			pending_q  <= 1'b0;
			fill_cnt_q <= '0;
			wb_cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc && in_cpu && !pending_q) begin
						state_q <= S_LOOKUP;
					end else if (fill_hit) begin
						if (fill_last) begin
							fill_cnt_q <= '0;
							state_q    <= S_ACC_RD;
						end else begin
							fill_cnt_q <= fill_cnt_q + WORD_W'(1);
						end
					end
				end
				S_LOOKUP: begin
					if (hit_any) begin
						state_q <= S_ACC_DN;
					end else if (status_row_s1[vic_way] == swlc_pkg::ST_DIRTY) begin
						wb_cnt_q <= '0;
						state_q  <= S_WB_RD;
					end else begin
						state_q <= S_FILLREQ;
					end
				end
				S_ACC_RD: state_q <= S_ACC_DN;
				S_ACC_DN: begin
					if (slot_free) begin
						pending_q <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				S_WB_RD: state_q <= S_WB_EMIT;
				S_WB_EMIT: begin
					if (slot_free) begin
						if (wb_cnt_q == WORD_W'(swlc_pkg::LINE_WORDS - 1)) begin
							state_q <= S_FILLREQ;
						end else begin
							wb_cnt_q <= wb_cnt_q + WORD_W'(1);
							state_q  <= S_WB_RD;
						end
					end
				end
				S_FILLREQ: begin
					if (slot_free) begin
						pending_q  <= 1'b1;
						fill_cnt_q <= '0;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// checks
	`SWLC_ASSERT_NEXT(a_busy_reject, in_acc && in_cpu && pending_q, out_valid_q && kind_q == swlc_pkg::KIND_REJECT, "busy access not rejected")
	`SWLC_ASSERT_NOW(a_ram_one_port, ram_req.we, !ram_req.re, "data memory read and write together")
	`SWLC_ASSERT_NEXT(a_fill_req_pends, state_q == S_FILLREQ && slot_free, pending_q && state_q == S_IDLE, "fill request without pending miss")
	`SWLC_ASSERT_NOW(a_no_lookup_pending, pending_q, state_q != S_LOOKUP && state_q != S_WB_RD && state_q != S_WB_EMIT, "lookup while miss pending")
endmodule

>>> sv/swlc_line_ram.sv
module swlc_line_ram (
	input  logic                            clk,
	input  swlc_pkg::ram_req_t              req,
	output logic [swlc_pkg::DATA_W-1:0]     rdata
);
	logic [swlc_pkg::DATA_W-1:0] mem [swlc_pkg::RAM_DEPTH];
	logic [swlc_pkg::DATA_W-1:0] rdata_q;

	// single port, registered read
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.addr];
		end
	end

	assign rdata = rdata_q;
endmodule

>>> dv/tb_set_assoc_writeback_lru_cache_top.sv
`timescale 1ns / 1ps
module tb_set_assoc_writeback_lru_cache_top;
	localparam int RUN_LIMIT = 400000;

	typedef struct {
		logic [1:0]  mode;
		logic [31:0] addr;
		logic [1:0]  lg;
		logic [63:0] data;
		logic [7:0]  id;
	} cpu_word_t;

	typedef struct {
		logic [2:0]  kind;
		logic [7:0]  id;
		logic [63:0] payload;
		logic [31:0] maddr;
		logic        last;
	} result_word_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  mode = '0;
	logic [31:0] address = '0;
	logic [1:0]  access_bytes_log2 = '0;
	logic [63:0] data = '0;
	logic [7:0]  cpu_tag = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  kind;
	logic [7:0]  response_id;
	logic [63:0] payload;
	logic [31:0] memory_address;
	logic        last;

	set_assoc_writeback_lru_cache_top u_top (.*);

	cpu_word_t    stim_q[$];
	result_word_t result_q[$];
	int           errors = 0;
	int           cycles = 0;
	int           n_hits, n_misses, n_evicts, n_busy;

	// shadow copy of the cache
	logic [19:0] sh_tag[swlc_pkg::SETS*swlc_pkg::WAYS];
	logic [1:0]  sh_status[swlc_pkg::SETS*swlc_pkg::WAYS];
	logic [1:0]  sh_age[swlc_pkg::SETS*swlc_pkg::WAYS];
	logic [63:0] sh_word[swlc_pkg::SETS*swlc_pkg::WAYS*swlc_pkg::LINE_WORDS];
	bit          sh_pending;
	cpu_word_t   sh_saved;
	int          sh_fill_cnt;
	int          sh_way;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycles <= cycles + 1;

	// calm window: no idling on either side
	function automatic bit idle_now();
		if (cycles > 300 && cycles < 800)
			return 0;
		return $urandom_range(99) < 19;
	endfunction

	function automatic void push_result(logic [2:0] k, logic [7:0] id, logic [63:0] p,
		logic [31:0] ma, logic l);
		result_word_t r;
		r.kind = k; r.id = id; r.payload = p; r.maddr = ma; r.last = l;
		result_q.push_back(r);
	endfunction

	function automatic void age_touch(int s, int w);
		logic [1:0] old_age;
		old_age = sh_age[s*swlc_pkg::WAYS+w];
		for (int i = 0; i < swlc_pkg::WAYS; i++)
			if (i != w && sh_age[s*swlc_pkg::WAYS+i] < old_age)
				sh_age[s*swlc_pkg::WAYS+i]++;
		sh_age[s*swlc_pkg::WAYS+w] = '0;
	endfunction

	// read or merge on a resident line; returns nothing, queues one result
	function automatic void line_access(int s, int w, cpu_word_t c, logic l);
		int          idx;
		int          sh;
		logic [63:0] m;
		idx = (s*swlc_pkg::WAYS + w)*swlc_pkg::LINE_WORDS + c.addr[5:3];
		sh  = c.addr[2:0] * 8;
		m   = (c.lg == 3) ? '1 : ((64'd1 << (8 << c.lg)) - 1);
		if (c.mode == swlc_pkg::MODE_WRITE) begin
			sh_word[idx] = (sh_word[idx] & ~(m << sh)) | ((c.data & m) << sh);
			sh_status[s*swlc_pkg::WAYS+w] = swlc_pkg::ST_DIRTY;
			push_result(swlc_pkg::KIND_WACK, c.id, '0, '0, l);
		end else begin
			push_result(swlc_pkg::KIND_RDATA, c.id, (sh_word[idx] >> sh) & m, '0, l);
		end
	endfunction

	// expected results of one accepted word
	function automatic void cache_predict(cpu_word_t c);
		int s, w, b;
		c.addr &= ~((32'd1 << c.lg) - 1);
		if (c.mode == swlc_pkg::MODE_FILL) begin
			if (!sh_pending)
				return;
			s = sh_saved.addr[11:6];
			sh_word[(s*swlc_pkg::WAYS + sh_way)*swlc_pkg::LINE_WORDS + sh_fill_cnt] = c.data;
			if (sh_fill_cnt + 1 < swlc_pkg::LINE_WORDS) begin
				sh_fill_cnt++;
				return;
			end
			sh_status[s*swlc_pkg::WAYS+sh_way] = swlc_pkg::ST_VALID;
			sh_tag[s*swlc_pkg::WAYS+sh_way] = sh_saved.addr[31:12];
			line_access(s, sh_way, sh_saved, 1'b1);
			sh_pending = 0;
			sh_fill_cnt = 0;
			return;
		end
		if (c.mode == 2'd3)
			return;
		if (sh_pending) begin
			n_busy++;
			push_result(swlc_pkg::KIND_REJECT, c.id, '0, '0, 1'b1);
			return;
		end
		s = c.addr[11:6];
		b = s*swlc_pkg::WAYS;
		for (w = 0; w < swlc_pkg::WAYS; w++)
			if (sh_status[b+w] != swlc_pkg::ST_INVALID && sh_tag[b+w] == c.addr[31:12])
				break;
		if (w < swlc_pkg::WAYS) begin
			n_hits++;
			line_access(s, w, c, 1'b1);
			age_touch(s, w);
			return;
		end
		n_misses++;
		w = 0;
		for (int i = 1; i < swlc_pkg::WAYS; i++)
			if (sh_age[b+i] > sh_age[b+w])
				w = i;
		if (sh_status[b+w] == swlc_pkg::ST_DIRTY) begin
			n_evicts++;
			for (int i = 0; i < swlc_pkg::LINE_WORDS; i++)
				push_result(swlc_pkg::KIND_WB, '0, sh_word[(b+w)*swlc_pkg::LINE_WORDS+i],
					{sh_tag[b+w], s[5:0], 6'd0}, 1'b0);
		end
		sh_status[b+w] = swlc_pkg::ST_INVALID;
		age_touch(s, w);
		push_result(swlc_pkg::KIND_FILLRQ, '0, '0, {c.addr[31:6], 6'd0}, 1'b1);
		sh_saved = c;
		sh_way = w;
		sh_fill_cnt = 0;
		sh_pending = 1;
	endfunction

	function automatic void add_word(logic [1:0] md, logic [31:0] a, logic [1:0] lg,
		logic [63:0] d, logic [7:0] id);
		cpu_word_t c;
		c.mode = md; c.addr = a; c.lg = lg; c.data = d; c.id = id;
		stim_q.push_back(c);
		cache_predict(c);
	endfunction

	// address from a narrow pool of tags and sets so lines conflict and hit
	function automatic logic [31:0] pick_addr();
		logic [19:0] tg;
		logic [5:0]  st;
		if ($urandom_range(9) == 0)
			return $urandom;
		case ($urandom_range(5))
			0: tg = '0;
			1: tg = '1;
			default: tg = 20'($urandom_range(5) * 20'h1357);
		endcase
		st = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(2));
		return {tg, st, 6'($urandom)};
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			mode <= '0; address <= '0; access_bytes_log2 <= '0; data <= '0; cpu_tag <= '0;
		end else if (!in_valid || in_ready) begin
			if (stim_q.size() == 0 || idle_now()) begin
				in_valid <= 0;
			end else begin
				cpu_word_t c;
				c = stim_q.pop_front();
				in_valid <= 1;
				mode <= c.mode; address <= c.addr; access_bytes_log2 <= c.lg;
				data <= c.data; cpu_tag <= c.id;
			end
		end
	end

	// result monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
		end else begin
			out_ready <= !idle_now();
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					report("unexpected word", 64'(kind), '0);
				end else begin
					result_word_t r;
					r = result_q.pop_front();
					if (kind !== r.kind) report("kind", 64'(kind), 64'(r.kind));
					if (response_id !== r.id)
						report("response_id", 64'(response_id), 64'(r.id));
					if (payload !== r.payload) report("payload", payload, r.payload);
					if (memory_address !== r.maddr)
						report("memory_address", 64'(memory_address), 64'(r.maddr));
					if (last !== r.last) report("last", 64'(last), 64'(r.last));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > RUN_LIMIT) begin
			$display("timeout with %0d results outstanding", result_q.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		logic [31:0] a;
		n_hits = 0; n_misses = 0; n_evicts = 0; n_busy = 0;
		for (int i = 0; i < swlc_pkg::SETS*swlc_pkg::WAYS; i++) begin
			sh_status[i] = swlc_pkg::ST_INVALID;
			sh_age[i] = 2'(swlc_pkg::WAYS - 1 - (i % swlc_pkg::WAYS));
			sh_tag[i] = '0;
		end
		sh_pending = 0;
		arst_n = 0;

		// directed: stray fill, unused mode, top address write miss, busy reject,
		// fill, then hits of every size, misaligned, extreme data and tags
		add_word(swlc_pkg::MODE_FILL, '0, '0, '1, 8'd0);
		add_word(2'd3, '1, 2'd3, '1, 8'hFF);
		add_word(swlc_pkg::MODE_WRITE, 32'hFFFF_FFFF, 2'd0, '1, 8'hFF);
		add_word(swlc_pkg::MODE_READ, 32'h0000_0040, 2'd3, '0, 8'h00);
		for (int i = 0; i < swlc_pkg::LINE_WORDS; i++)
			add_word(swlc_pkg::MODE_FILL, $urandom, '0, {$urandom, $urandom}, '0);
		for (int lg = 0; lg < 4; lg++)
			add_word(swlc_pkg::MODE_READ, 32'hFFFF_FFFF, 2'(lg), '0, 8'(lg));
		add_word(swlc_pkg::MODE_WRITE, 32'hFFFF_FFF3, 2'd2, 64'h0123_4567_89AB_CDEF, 8'h80);
		add_word(swlc_pkg::MODE_READ, 32'hFFFF_FFF8, 2'd3, '0, 8'h7F);
		add_word(swlc_pkg::MODE_WRITE, 32'hFFFF_FFC0, 2'd3, '0, 8'h01);
		add_word(swlc_pkg::MODE_READ, 32'hFFFF_FFC0, 2'd1, '0, 8'h02);

		// random: mostly well-formed miss/fill sequences, some noise
		for (int n = 0; n < 250; n++) begin
			if (sh_pending) begin
				if ($urandom_range(99) < 88)
					add_word(swlc_pkg::MODE_FILL, $urandom, 2'($urandom),
						{$urandom, $urandom}, 8'($urandom));
				else
					add_word(2'($urandom_range(3)), pick_addr(), 2'($urandom),
						{$urandom, $urandom}, 8'($urandom));
			end else begin
				case ($urandom_range(19))
					0: add_word(2'd3, $urandom, 2'($urandom), {$urandom, $urandom}, 8'($urandom));
					1: add_word(swlc_pkg::MODE_FILL, $urandom, 2'($urandom),
						{$urandom, $urandom}, 8'($urandom));
					default: begin
						a = pick_addr();
						add_word(2'($urandom_range(1)), a, 2'($urandom), {$urandom, $urandom},
							8'($urandom));
					end
				endcase
			end
		end
		// finish any open miss so it completes
		while (sh_pending)
			add_word(swlc_pkg::MODE_FILL, '0, '0, {$urandom, $urandom}, '0);

		repeat (9) @(posedge clk);
		arst_n <= 1;
		wait (stim_q.size() == 0 && result_q.size() == 0);
		repeat (30) @(posedge clk);
		$display("covered %0d hits, %0d misses, %0d dirty evictions, %0d busy rejects",
			n_hits, n_misses, n_evicts, n_busy);
		if (errors == 0 && result_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

>>> files.f
+incdir+sv
sv/swlc_pkg.sv
sv/swlc_line_ram.sv
sv/set_assoc_writeback_lru_cache_top.sv
dv/tb_set_assoc_writeback_lru_cache_top.sv
